[hw/rtl/rgb_to_hsl_integer_defines.svh]
// Assertion macros shared by the RGB to HSL pipeline.
`ifndef RGB_TO_HSL_INTEGER_DEFINES_SVH
`define RGB_TO_HSL_INTEGER_DEFINES_SVH

// Plain clocked check, off while reset is held.
`define RTH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication check, off while reset is held.
`define RTH_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

[hw/rtl/rth_pkg.sv]
// Shared constants, types and stage map for the RGB to HSL pipeline.
`default_nettype none

package rth_pkg;

    // Field widths
    localparam int unsigned CH_W    = 8;   // one color channel
    localparam int unsigned HUE_W   = 9;   // 0..360
    localparam int unsigned PCT_OUT = 7;   // 0..100
    localparam int unsigned SCL_W   = 18;  // scaled values up to 255000
    localparam int unsigned PCT_W   = 10;  // per-mille values 0..1000
    localparam int unsigned SECT_W  = 13;  // sector in thousandths, 0..6000
    localparam int unsigned HUE6_W  = 16;  // sector*6 + 50

    // Pipelined divider geometry
    localparam int unsigned DIV_NUM_W  = 20;
    localparam int unsigned DIV_DEN_W  = 11;
    localparam int unsigned DIV_Q_W    = 10;
    localparam int unsigned DIV_BPS    = 2;
    localparam int unsigned DIV_STAGES = DIV_Q_W / DIV_BPS;

    // Stage map of the top level
    localparam int unsigned ST_A        = 0;  // max/min/dominant channel
    localparam int unsigned ST_B        = 1;  // scale products
    localparam int unsigned ST_C        = 2;  // /255 reciprocal estimate
    localparam int unsigned ST_D        = 3;  // /255 correction
    localparam int unsigned ST_E        = 4;  // lightness, divider operands
    localparam int unsigned DIV_FIRST   = 5;
    localparam int unsigned ST_G        = DIV_FIRST + DIV_STAGES;  // sat round, hue*6
    localparam int unsigned ST_H        = ST_G + 1;                // hue round
    localparam int unsigned PIPE_STAGES = ST_H + 1;

    // Arithmetic constants
    localparam logic [9:0]  K_LIGHT      = 10'd500;
    localparam logic [9:0]  K_MILLE      = 10'd1000;
    localparam logic [11:0] K_SAT_FULL   = 12'd2000;
    localparam logic [7:0]  K_255        = 8'd255;
    localparam logic [15:0] RECIP_255    = 16'd32896;  // floor(2^23/255)
    localparam int unsigned RECIP_255_SH = 23;
    localparam logic [7:0]  RECIP_10     = 8'd205;     // exact /10 below 1029
    localparam int unsigned RECIP_10_SH  = 11;
    localparam logic [12:0] RECIP_100    = 13'd5243;   // exact /100 below 43699
    localparam int unsigned RECIP_100_SH = 19;
    localparam logic [3:0]  HALF_TENTH   = 4'd5;
    localparam logic [6:0]  HALF_HUNDRED = 7'd50;
    localparam logic [9:0]  LIGHT_LOW_MAX = 10'd504;   // lt <= 504 gives light <= 50
    localparam logic [2:0]  K_SIX        = 3'd6;

    // Sector offsets in thousandths
    localparam logic [SECT_W-1:0] OFS_RED_WRAP = 13'd6000;
    localparam logic [SECT_W-1:0] OFS_GREEN    = 13'd2000;
    localparam logic [SECT_W-1:0] OFS_BLUE     = 13'd4000;

    typedef enum logic [1:0] {
        DOM_RED   = 2'd0,
        DOM_GREEN = 2'd1,
        DOM_BLUE  = 2'd2
    } t_dom;

endpackage

`default_nettype wire

[hw/rtl/rth_div.sv]
// Pipelined restoring divider, two quotient bits per stage.
`default_nettype none

module rth_div
    import rth_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [DIV_STAGES-1:0] i_en,   // per-stage load enable
    input  wire logic [DIV_NUM_W-1:0]  i_num,
    input  wire logic [DIV_DEN_W-1:0]  i_den,
    output logic      [DIV_Q_W-1:0]    o_quo
);

    // Quotient must fit DIV_Q_W bits, so the top numerator bits start
    // out as a partial remainder below the divisor.
    logic [DIV_DEN_W-1:0] r_rem  [DIV_STAGES];
    logic [DIV_Q_W-1:0]   r_bits [DIV_STAGES];
    logic [DIV_Q_W-1:0]   r_quo  [DIV_STAGES];
    logic [DIV_DEN_W-1:0] r_den  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_Q_W-1:0]   bits_in;
        logic [DIV_Q_W-1:0]   quo_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_DEN_W-1:0] n_rem;
        logic [DIV_Q_W-1:0]   n_bits;
        logic [DIV_Q_W-1:0]   n_quo;

        if (k == 0) begin : g_head
            assign rem_in  = i_num[DIV_NUM_W-1 -: DIV_DEN_W-1] == '0 ? '0 :
                             DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_Q_W]);
            assign bits_in = i_num[DIV_Q_W-1:0];
            assign quo_in  = '0;
            assign den_in  = i_den;
        end else begin : g_body
            assign rem_in  = r_rem[k-1];
            assign bits_in = r_bits[k-1];
            assign quo_in  = r_quo[k-1];
            assign den_in  = r_den[k-1];
        end

        always_comb begin
            logic [DIV_DEN_W:0] trial;
            n_rem  = rem_in;
            n_bits = bits_in;
            n_quo  = quo_in;
            for (int s = 0; s < DIV_BPS; s++) begin
                trial  = {n_rem, n_bits[DIV_Q_W-1]};
                n_bits = {n_bits[DIV_Q_W-2:0], 1'b0};
                if (trial >= {1'b0, den_in}) begin
                    n_rem = DIV_DEN_W'(trial - {1'b0, den_in});
                    n_quo = {n_quo[DIV_Q_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[DIV_DEN_W-1:0];
                    n_quo = {n_quo[DIV_Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= n_rem;
                r_bits[k] <= n_bits;
                r_quo[k]  <= n_quo;
                r_den[k]  <= den_in;
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/rgb_to_hsl_integer.sv]
// Top level: 24-bit RGB pixel in, integer hue/saturation/lightness out.
//
//  channel   dir  word bits (low to high)
//  s_axis    in   [23:0] pixel_rgb (blue 7:0, green 15:8, red 23:16)
//  m_axis    out  [8:0] hue_degrees, [15:9] saturation_percent,
//                 [22:16] lightness_percent, [23] zero
//
// Twelve register stages: channel sort, scale products, /255 estimate,
// /255 correction, lightness and divider operands, five divider stages
// (two quotient bits each), saturation round with hue*6, hue round.
// One word per clock sustained while m_axis_tready stays high.
// Each stage loads when it is empty or the stage after it moves, so
// bubbles close up and input is taken while an output word waits.
// Reset (synchronous, active low) clears only the stage valid bits.
`default_nettype none

`include "rgb_to_hsl_integer_defines.svh"

module rgb_to_hsl_integer
    import rth_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] pixel_rgb

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata    // [8:0] hue, [15:9] sat, [22:16] light
);

    typedef struct packed {
        logic [PCT_OUT-1:0] light;
        logic               grey;
        logic               neg;
        t_dom               dom;
    } t_side;

    // ------------------------------------------------------------------
    // Flow control: stage k loads when it is empty or stage k+1 loads.
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] pipe_en;

    always_comb begin
        pipe_en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || m_axis_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            pipe_en[k] = !r_vld[k] || pipe_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (pipe_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (pipe_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = pipe_en[ST_A];

    // ------------------------------------------------------------------
    // Stage A: sort channels, pick dominant one and its difference.
    // Ties go red, then green, as the hue sectors require.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] rc, gc, bc, n_hi, n_lo;
    t_dom            n_dom;
    logic signed [CH_W:0] n_diff;

    always_comb begin
        logic [CH_W-1:0] t_max, t_min;
        rc = s_axis_tdata[23:16];
        gc = s_axis_tdata[15:8];
        bc = s_axis_tdata[7:0];
        t_max = (rc > gc) ? rc : gc;
        n_hi  = (t_max > bc) ? t_max : bc;
        t_min = (rc < gc) ? rc : gc;
        n_lo  = (t_min < bc) ? t_min : bc;
        if (n_hi == rc)       n_dom = DOM_RED;
        else if (n_hi == gc)  n_dom = DOM_GREEN;
        else                  n_dom = DOM_BLUE;
        unique case (n_dom)
            DOM_RED:   n_diff = $signed({1'b0, gc}) - $signed({1'b0, bc});
            DOM_GREEN: n_diff = $signed({1'b0, bc}) - $signed({1'b0, rc});
            DOM_BLUE:  n_diff = $signed({1'b0, rc}) - $signed({1'b0, gc});
            default:   n_diff = '0;
        endcase
    end

    logic [CH_W-1:0]      r_a_hi, r_a_lo;
    t_dom                 r_a_dom;
    logic signed [CH_W:0] r_a_diff;

    always_ff @(posedge i_clk) begin
        if (pipe_en[ST_A]) begin
            r_a_hi   <= n_hi;
            r_a_lo   <= n_lo;
            r_a_dom  <= n_dom;
            r_a_diff <= n_diff;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: (hi+lo)*500, hi*1000, lo*1000, |diff|*1000, span.
    // Index 0 feeds lightness, 1 and 2 the scaled max and min.
    // ------------------------------------------------------------------
    logic [SCL_W-1:0] n_b_x [3];
    logic [SCL_W-1:0] n_b_dnum;
    logic             n_b_neg;
    logic [CH_W:0]    sum9, mag9;

    always_comb begin
        sum9     = {1'b0, r_a_hi} + {1'b0, r_a_lo};
        n_b_x[0] = SCL_W'(sum9 * K_LIGHT);
        n_b_x[1] = SCL_W'(r_a_hi * K_MILLE);
        n_b_x[2] = SCL_W'(r_a_lo * K_MILLE);
        n_b_neg  = r_a_diff[CH_W];
        mag9     = n_b_neg ? (CH_W+1)'(-r_a_diff) : r_a_diff;
        n_b_dnum = SCL_W'(mag9[CH_W-1:0] * K_MILLE);
    end

    logic [SCL_W-1:0] r_b_x [3];
    logic [SCL_W-1:0] r_b_dnum;
    logic             r_b_neg;
    logic [CH_W-1:0]  r_b_span;
    t_dom             r_b_dom;

    always_ff @(posedge i_clk) begin
        if (pipe_en[ST_B]) begin
            r_b_x    <= n_b_x;
            r_b_dnum <= n_b_dnum;
            r_b_neg  <= n_b_neg;
            r_b_span <= r_a_hi - r_a_lo;
            r_b_dom  <= r_a_dom;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: x/255 estimate by reciprocal; low by at most one.
    // ------------------------------------------------------------------
    logic [PCT_W-1:0] n_c_est [3];

    always_comb begin
        logic [SCL_W+15:0] prod;
        for (int i = 0; i < 3; i++) begin
            prod       = r_b_x[i] * RECIP_255;
            n_c_est[i] = prod[RECIP_255_SH +: PCT_W];
        end
    end

    logic [SCL_W-1:0] r_c_x   [3];
    logic [PCT_W-1:0] r_c_est [3];
    logic [SCL_W-1:0] r_c_dnum;
    logic             r_c_neg;
    logic [CH_W-1:0]  r_c_span;
    t_dom             r_c_dom;

    always_ff @(posedge i_clk) begin
        if (pipe_en[ST_C]) begin
            r_c_x    <= r_b_x;
            r_c_est  <= n_c_est;
            r_c_dnum <= r_b_dnum;
            r_c_neg  <= r_b_neg;
            r_c_span <= r_b_span;
            r_c_dom  <= r_b_dom;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: one compare-subtract fixes the /255 quotient.
    // ------------------------------------------------------------------
    logic [PCT_W-1:0] n_d_q [3];

    always_comb begin
        logic [SCL_W-1:0] rem;
        for (int i = 0; i < 3; i++) begin
            rem      = r_c_x[i] - SCL_W'(r_c_est[i] * K_255);
            n_d_q[i] = (rem >= SCL_W'(K_255)) ? PCT_W'(r_c_est[i] + 1'b1) : r_c_est[i];
        end
    end

    logic [PCT_W-1:0] r_d_q [3];   // lt, sh, sl
    logic [SCL_W-1:0] r_d_dnum;
    logic             r_d_neg;
    logic [CH_W-1:0]  r_d_span;
    t_dom             r_d_dom;

    always_ff @(posedge i_clk) begin
        if (pipe_en[ST_D]) begin
            r_d_q    <= n_d_q;
            r_d_dnum <= r_c_dnum;
            r_d_neg  <= r_c_neg;
            r_d_span <= r_c_span;
            r_d_dom  <= r_c_dom;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: round lightness, build both divider operand pairs.
    // ------------------------------------------------------------------
    logic [PCT_OUT-1:0]   n_e_light;
    logic [DIV_DEN_W-1:0] n_e_sden;
    logic [DIV_NUM_W-1:0] n_e_snum;

    always_comb begin
        logic [PCT_W-1:0]   lt_rnd;
        logic [PCT_W+7:0]   lprod;
        logic [PCT_W-1:0]   sdiff;
        lt_rnd    = PCT_W'(r_d_q[0] + HALF_TENTH);
        lprod     = lt_rnd * RECIP_10;
        n_e_light = lprod[RECIP_10_SH +: PCT_OUT];
        if (r_d_q[0] <= LIGHT_LOW_MAX) begin
            n_e_sden = DIV_DEN_W'({1'b0, r_d_q[1]} + {1'b0, r_d_q[2]});
        end else begin
            n_e_sden = DIV_DEN_W'(K_SAT_FULL - 12'(r_d_q[1]) - 12'(r_d_q[2]));
        end
        sdiff    = r_d_q[1] - r_d_q[2];
        n_e_snum = DIV_NUM_W'(sdiff * K_MILLE);
    end

    logic [DIV_NUM_W-1:0] r_e_snum, r_e_hnum;
    logic [DIV_DEN_W-1:0] r_e_sden, r_e_hden;
    t_side                r_e_side;

    always_ff @(posedge i_clk) begin
        if (pipe_en[ST_E]) begin
            r_e_snum       <= n_e_snum;
            r_e_sden       <= n_e_sden;
            r_e_hnum       <= DIV_NUM_W'(r_d_dnum);
            r_e_hden       <= DIV_DEN_W'(r_d_span);
            r_e_side.light <= n_e_light;
            r_e_side.grey  <= (r_d_span == '0);
            r_e_side.neg   <= r_d_neg;
            r_e_side.dom   <= r_d_dom;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: saturation and hue quotients side by side.
    // ------------------------------------------------------------------
    logic [DIV_Q_W-1:0] sat_quo, hue_quo;

    rth_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (pipe_en[DIV_FIRST +: DIV_STAGES]),
        .i_num (r_e_snum),
        .i_den (r_e_sden),
        .o_quo (sat_quo)
    );

    rth_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (pipe_en[DIV_FIRST +: DIV_STAGES]),
        .i_num (r_e_hnum),
        .i_den (r_e_hden),
        .o_quo (hue_quo)
    );

    t_side r_side [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (pipe_en[DIV_FIRST]) begin
            r_side[0] <= r_e_side;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (pipe_en[DIV_FIRST + k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage G: round saturation, place hue in its sector, times 6 + 50.
    // ------------------------------------------------------------------
    t_side              div_side;
    logic [PCT_OUT-1:0] n_g_sat;
    logic [HUE6_W-1:0]  n_g_hue6;

    assign div_side = r_side[DIV_STAGES-1];

    always_comb begin
        logic [PCT_W-1:0]  s_rnd;
        logic [PCT_W+7:0]  sprod;
        logic [SECT_W-1:0] ofs, sector;
        s_rnd   = PCT_W'(sat_quo + HALF_TENTH);
        sprod   = s_rnd * RECIP_10;
        n_g_sat = div_side.grey ? '0 : sprod[RECIP_10_SH +: PCT_OUT];
        unique case (div_side.dom)
            DOM_RED:   ofs = div_side.neg ? OFS_RED_WRAP : '0;
            DOM_GREEN: ofs = OFS_GREEN;
            DOM_BLUE:  ofs = OFS_BLUE;
            default:   ofs = '0;
        endcase
        sector   = div_side.neg ? SECT_W'(ofs - hue_quo) : SECT_W'(ofs + hue_quo);
        n_g_hue6 = HUE6_W'(sector * K_SIX + HALF_HUNDRED);
    end

    logic [PCT_OUT-1:0] r_g_sat, r_g_light;
    logic [HUE6_W-1:0]  r_g_hue6;
    logic               r_g_grey;

    always_ff @(posedge i_clk) begin
        if (pipe_en[ST_G]) begin
            r_g_sat   <= n_g_sat;
            r_g_light <= div_side.light;
            r_g_hue6  <= n_g_hue6;
            r_g_grey  <= div_side.grey;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: hue /100 by reciprocal; this is the output register.
    // ------------------------------------------------------------------
    logic [HUE_W-1:0] n_h_hue;

    always_comb begin
        logic [HUE6_W+12:0] hprod;
        hprod   = r_g_hue6 * RECIP_100;
        n_h_hue = r_g_grey ? '0 : hprod[RECIP_100_SH +: HUE_W];
    end

    logic [HUE_W-1:0]   r_h_hue;
    logic [PCT_OUT-1:0] r_h_sat, r_h_light;

    always_ff @(posedge i_clk) begin
        if (pipe_en[ST_H]) begin
            r_h_hue   <= n_h_hue;
            r_h_sat   <= r_g_sat;
            r_h_light <= r_g_light;
        end
    end

    assign m_axis_tvalid = r_vld[ST_H];
    assign m_axis_tdata  = {1'b0, r_h_light, r_h_sat, r_h_hue};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic       in_fire, out_fire, quo_ok, out_ok;
    logic [3:0] occ, occ_exp;   // words held in the pipe, 0..12

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign occ      = 4'($countones(r_vld));
    assign occ_exp  = occ + {3'b0, in_fire} - {3'b0, out_fire};
    assign quo_ok   = (sat_quo <= K_MILLE) && (hue_quo <= K_MILLE);
    assign out_ok   = (r_h_hue <= 9'd360) && (r_h_sat <= 7'd100) && (r_h_light <= 7'd100);

    `RTH_ASSERT_IMPL(a_ready_on_bubble, !(&r_vld) || m_axis_tready, s_axis_tready, "stall with room")
    `RTH_ASSERT(a_occupancy, 1'b1 |=> (occ == $past(occ_exp)), "word lost or duplicated in pipe")
    `RTH_ASSERT_IMPL(a_quo_range, r_vld[ST_G-1] && !div_side.grey, quo_ok, "quotient out of range")
    `RTH_ASSERT_IMPL(a_out_range, m_axis_tvalid, out_ok, "result field out of range")

endmodule

`default_nettype wire
